[rtl/core/pipt_pkg.sv]
// Shared types, widths and constants for the power-invariant Park transform.
// Also holds the elaboration-time builder for the scaled quarter-wave sine table.
// No dependencies.
`timescale 1ns / 1ps

package pipt_pkg;

  localparam int unsigned SAMPLE_BITS         = 16;
  localparam int unsigned ANGLE_BITS          = 16;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;

  // Table entries are k*sin in Q1.15, magnitude below 0.82
  localparam int unsigned TRIG_W    = 16;
  localparam int unsigned NUM_LANES = 4;

  // sqrt(3) in Q16
  localparam int unsigned R2_W = 18;
  localparam logic signed [R2_W-1:0] R2_Q16 = 18'sd113512;

  // Lane operand: 2a-b-c or rounded sqrt3*(b-c), or a sample in inverse mode
  localparam int unsigned OPW    = SAMPLE_BITS + 2;
  localparam int unsigned PROD_W = TRIG_W + OPW;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned R2V_W  = SUM_W + R2_W;
  localparam int unsigned RES_W  = SUM_W + R2_W + 1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic {
    CMD_FWD = 1'b0,
    CMD_INV = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                          cmd;
    logic [ANGLE_BITS-1:0]         theta;
    logic signed [SAMPLE_BITS-1:0] in_a;
    logic signed [SAMPLE_BITS-1:0] in_b;
    logic signed [SAMPLE_BITS-1:0] in_c;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_a;
    logic signed [SAMPLE_BITS-1:0] out_b;
    logic signed [SAMPLE_BITS-1:0] out_c;
    logic                          saturated;
  } out_beat_t;

  typedef struct packed {
    logic vld;
    cmd_e cmd;
  } stage_ctl_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  // pi/2 in Q2.30
  localparam longint unsigned PIH_Q30 = 64'd1686629713;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bt;
    rem = v;
    res = 64'd0;
    bt  = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  localparam longint unsigned K_SQ_ARG = (64'd1 << 61) / 64'd3;
  // sqrt(2/3) in Q2.30
  localparam longint unsigned K_Q30 = isqrt64(K_SQ_ARG);

  // Entry idx of the table: k*sin(pi/2 * idx / 2^tb), Q1.15, Taylor series to x^15
  function automatic logic [TRIG_W-1:0] ktab_entry(input longint unsigned idx,
                                                   input int unsigned tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    x    = (PIH_Q30 * idx) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - term;
    acc  = (acc * K_Q30) >> 30;
    return TRIG_W'((acc + 64'd16384) >> 15);
  endfunction

endpackage

[rtl/core/power_invariant_park_transform.sv]
// Top level of the power-invariant Park / inverse Park transform.
// Depends on pipt_pkg, pipt_trig, pipt_lane, pipt_merge.
//
// Input beat: cmd, theta, in_a..in_c on in_valid_i/in_ready_o. cmd = forward
// takes phases a, b, c to d, q (out_c = 0); cmd = inverse takes d = in_a,
// q = in_b to phases a, b, c (in_c unused). Result beat on out_valid_o /
// out_ready_i carries out_a..out_c and a saturated flag.
// Throughput: one beat per clock while out_ready_i keeps taking results. Stages
// from accept to result valid: table read, lane multipliers, merge adders,
// sqrt3 multiplier, round/saturate output register.
// The whole pipeline advances whenever the output register is empty or being
// taken; a stalled receiver freezes every stage, and in_ready_o drops only
// while the output holds an untaken beat and out_ready_i is low.
// Reset clears only the stage control bits (valid, cmd). The sine table is a
// constant ROM, so the block accepts beats right after reset.
`timescale 1ns / 1ps

module power_invariant_park_transform import pipt_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned BE_PW = SAMPLE_BITS + 1 + R2_W;
  localparam logic signed [BE_PW-1:0] BE_HALF = BE_PW'(32768);

  logic                          pipe_en;
  logic                          fwd_in, fwd1;
  logic signed [OPW-1:0]         alpha, beta, opx_d, opy_d, s1_opx_q, s1_opy_q;
  logic signed [SAMPLE_BITS:0]   b_minus_c;
  logic signed [BE_PW-1:0]       be_prod, be_rnd;
  stage_ctl_t                    s1_ctl_d, s1_ctl_q, s2_ctl_q;
  logic signed [TRIG_W-1:0]      sn, cs;
  logic signed [TRIG_W-1:0]      lane_trig [NUM_LANES];
  logic signed [OPW-1:0]         lane_op   [NUM_LANES];
  prod_t                         lane_prod [NUM_LANES];

  assign pipe_en    = !out_valid_o || out_ready_i;
  assign in_ready_o = pipe_en;

  // forward pre-rotation: alpha = 2a - b - c, beta = sqrt3 * (b - c)
  assign fwd_in    = (in_beat_i.cmd == CMD_FWD);
  assign alpha     = (OPW'(in_beat_i.in_a) <<< 1) - OPW'(in_beat_i.in_b)
                     - OPW'(in_beat_i.in_c);
  assign b_minus_c = (SAMPLE_BITS+1)'(in_beat_i.in_b) - (SAMPLE_BITS+1)'(in_beat_i.in_c);
  assign be_prod   = BE_PW'(b_minus_c) * BE_PW'(R2_Q16);
  assign be_rnd    = (be_prod + BE_HALF) >>> 16;
  assign beta      = be_rnd[OPW-1:0];
  assign opx_d     = fwd_in ? alpha : OPW'(in_beat_i.in_a);
  assign opy_d     = fwd_in ? beta  : OPW'(in_beat_i.in_b);

  assign s1_ctl_d.vld = in_valid_i;
  assign s1_ctl_d.cmd = in_beat_i.cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
    end else if (pipe_en) begin
      s1_ctl_q <= s1_ctl_d;
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_opx_q <= opx_d;
      s1_opy_q <= opy_d;
    end
  end

  pipt_trig #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_trig (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .theta_i(in_beat_i.theta),
    .sin_o  (sn),
    .cos_o  (cs)
  );

  // forward: cs*al, sn*be, cs*be, sn*al; inverse: cs*d, sn*q, sn*d, cs*q
  assign fwd1         = (s1_ctl_q.cmd == CMD_FWD);
  assign lane_trig[0] = cs;
  assign lane_trig[1] = sn;
  assign lane_trig[2] = fwd1 ? cs : sn;
  assign lane_trig[3] = fwd1 ? sn : cs;
  assign lane_op[0]   = s1_opx_q;
  assign lane_op[1]   = s1_opy_q;
  assign lane_op[2]   = fwd1 ? s1_opy_q : s1_opx_q;
  assign lane_op[3]   = fwd1 ? s1_opx_q : s1_opy_q;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pipt_lane u_lane (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .trig_i(lane_trig[g]),
      .op_i  (lane_op[g]),
      .prod_o(lane_prod[g])
    );
  end

  pipt_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .ctl_i      (s2_ctl_q),
    .prod_i     (lane_prod),
    .out_valid_o(out_valid_o),
    .out_beat_o (out_beat_o)
  );

endmodule

[rtl/core/pipt_trig.sv]
// Angle to scaled sine/cosine: quarter-wave ROM with two registered read ports.
// Depends on pipt_pkg.
`timescale 1ns / 1ps

module pipt_trig import pipt_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ANGLE_BITS-1:0]    theta_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int unsigned PB    = TABLE_ADDR_BITS + 2;
  localparam int unsigned DEPTH = (1 << TABLE_ADDR_BITS) + 1;
  localparam int unsigned AW    = TABLE_ADDR_BITS + 1;

  function automatic logic [DEPTH*TRIG_W-1:0] build_tab();
    logic [DEPTH*TRIG_W-1:0] t;
    t = '0;
    for (int i = 0; i < DEPTH; i++) begin
      t[i*TRIG_W +: TRIG_W] = ktab_entry(64'(i), TABLE_ADDR_BITS);
    end
    return t;
  endfunction

  localparam logic [DEPTH*TRIG_W-1:0] KTAB = build_tab();

  logic [PB-1:0]              phase;
  logic [1:0]                 quad_sn;
  logic [1:0]                 quad_cs;
  logic [TABLE_ADDR_BITS-1:0] frac;
  logic [AW-1:0]              addr_fold;
  logic [AW-1:0]              addr_sn;
  logic [AW-1:0]              addr_cs;
  logic [TRIG_W-1:0]          tab_sn_q;
  logic [TRIG_W-1:0]          tab_cs_q;
  logic                       neg_sn_q;
  logic                       neg_cs_q;

  // low angle bits are dropped; a narrow angle is padded on the right
  generate
    if (ANGLE_BITS >= PB) begin : g_trunc
      assign phase = theta_i[ANGLE_BITS-1 -: PB];
    end else begin : g_pad
      assign phase = {theta_i, {(PB - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  assign quad_sn   = phase[PB-1 -: 2];
  assign quad_cs   = quad_sn + 2'd1;   // cos = sin a quarter turn later
  assign frac      = phase[TABLE_ADDR_BITS-1:0];
  assign addr_fold = {1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, frac};
  assign addr_sn   = quad_sn[0] ? addr_fold : {1'b0, frac};
  assign addr_cs   = quad_cs[0] ? addr_fold : {1'b0, frac};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tab_sn_q <= KTAB[addr_sn*TRIG_W +: TRIG_W];
      tab_cs_q <= KTAB[addr_cs*TRIG_W +: TRIG_W];
      neg_sn_q <= quad_sn[1];
      neg_cs_q <= quad_cs[1];
    end
  end

  assign sin_o = neg_sn_q ? -$signed(tab_sn_q) : $signed(tab_sn_q);
  assign cos_o = neg_cs_q ? -$signed(tab_cs_q) : $signed(tab_cs_q);

endmodule

[rtl/core/pipt_lane.sv]
// One multiplier lane: trig value times operand, registered product.
// Depends on pipt_pkg.
`timescale 1ns / 1ps

module pipt_lane import pipt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [TRIG_W-1:0] trig_i,
  input  logic signed [OPW-1:0]    op_i,
  output prod_t                    prod_o
);

  prod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(trig_i) * PROD_W'(op_i);
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/core/pipt_merge.sv]
// Merge stage: combines lane products, applies the sqrt3 term for the inverse,
// then rounds, saturates and holds the result beat. Depends on pipt_pkg.
`timescale 1ns / 1ps

module pipt_merge import pipt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  stage_ctl_t ctl_i,
  input  prod_t      prod_i [NUM_LANES],
  output logic       out_valid_o,
  output out_beat_t  out_beat_o
);

  localparam logic signed [RES_W-1:0] HALF15 = RES_W'(64'd1 << 14);
  localparam logic signed [RES_W-1:0] HALF16 = RES_W'(64'd1 << 15);
  localparam logic signed [RES_W-1:0] HALF32 = RES_W'(64'd1 << 31);
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(SAMPLE_MAX);
  localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(SAMPLE_MIN);

  // {clipped, value}
  function automatic logic [SAMPLE_BITS:0] sat_f(input logic signed [RES_W-1:0] v);
    if (v > SAT_HI) return {1'b1, SAMPLE_MAX};
    else if (v < SAT_LO) return {1'b1, SAMPLE_MIN};
    else return {1'b0, v[SAMPLE_BITS-1:0]};
  endfunction

  stage_ctl_t               s3_ctl_q, s4_ctl_q;
  logic signed [SUM_W-1:0]  s3_x_d, s3_y_d, s3_x_q, s3_y_q;
  logic signed [SUM_W-1:0]  s4_x_q, s4_y_q;
  logic signed [R2V_W-1:0]  s4_r2v_q;
  logic                     fwd3;
  logic signed [SUM_W-1:0]  p1_ext, p3_ext;
  logic signed [RES_W-1:0]  xe, ye, uh, r2v, res_a, res_b, res_c;
  logic [SAMPLE_BITS:0]     sat_a, sat_b, sat_c;
  logic                     out_vld_q;
  out_beat_t                out_beat_d, out_beat_q;

  // forward: d = p0 + p1, q = p2 - p3; inverse: u = p0 - p1, v = p2 + p3
  assign fwd3   = (ctl_i.cmd == CMD_FWD);
  assign p1_ext = SUM_W'(prod_i[1]);
  assign p3_ext = SUM_W'(prod_i[3]);
  assign s3_x_d = SUM_W'(prod_i[0]) + (fwd3 ? p1_ext : -p1_ext);
  assign s3_y_d = SUM_W'(prod_i[2]) + (fwd3 ? -p3_ext : p3_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q  <= '0;
      s4_ctl_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_ctl_q  <= ctl_i;
      s4_ctl_q  <= s3_ctl_q;
      out_vld_q <= s4_ctl_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_x_q     <= s3_x_d;
      s3_y_q     <= s3_y_d;
      s4_x_q     <= s3_x_q;
      s4_y_q     <= s3_y_q;
      s4_r2v_q   <= R2V_W'(s3_y_q) * R2V_W'(R2_Q16);
      out_beat_q <= out_beat_d;
    end
  end

  always_comb begin
    xe  = RES_W'(s4_x_q);
    ye  = RES_W'(s4_y_q);
    r2v = RES_W'(s4_r2v_q);
    uh  = -(xe <<< 16);
    if (s4_ctl_q.cmd == CMD_FWD) begin
      res_a = (xe + HALF16) >>> 16;
      res_b = (ye + HALF16) >>> 16;
      res_c = '0;
    end else begin
      res_a = (xe + HALF15) >>> 15;
      res_b = (uh + r2v + HALF32) >>> 32;
      res_c = (uh - r2v + HALF32) >>> 32;
    end
    sat_a = sat_f(res_a);
    sat_b = sat_f(res_b);
    sat_c = sat_f(res_c);
    out_beat_d.out_a     = sat_a[SAMPLE_BITS-1:0];
    out_beat_d.out_b     = sat_b[SAMPLE_BITS-1:0];
    out_beat_d.out_c     = sat_c[SAMPLE_BITS-1:0];
    out_beat_d.saturated = sat_a[SAMPLE_BITS] | sat_b[SAMPLE_BITS] | sat_c[SAMPLE_BITS];
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_beat_q;

endmodule

[rtl/core/pipt_checker.sv]
// Port-level checks for power_invariant_park_transform, attached by bind.
// Depends on pipt_pkg.
`timescale 1ns / 1ps

module pipt_checker import pipt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_beat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_beat_o))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    ##1 out_ready_i |=> out_valid_o)
    else $error("result not valid five cycles after accept");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.saturated |->
      (out_beat_o.out_a == SAMPLE_MAX || out_beat_o.out_a == SAMPLE_MIN ||
       out_beat_o.out_b == SAMPLE_MAX || out_beat_o.out_b == SAMPLE_MIN ||
       out_beat_o.out_c == SAMPLE_MAX || out_beat_o.out_c == SAMPLE_MIN))
    else $error("saturated flag without a clipped field");

endmodule

bind power_invariant_park_transform pipt_checker u_pipt_checker (.*);

[bench/power_invariant_park_transform_tb.sv]
// Self-checking bench for the power-invariant Park / inverse Park transform.
// Predicts every result beat from its own fixed-point model; needs pipt_pkg
// and power_invariant_park_transform.
`timescale 1ns / 1ps

module power_invariant_park_transform_tb;
  import pipt_pkg::*;

  localparam int unsigned TAB_BITS  = TABLE_ADDR_BITS_DEF;
  localparam int unsigned TAB_N     = 1 << TAB_BITS;
  localparam int unsigned PHASE_W   = TAB_BITS + 2;
  localparam longint      SQRT3_Q16 = 113512;
  localparam longint      HALF_PI_Q30 = 1686629713;
  localparam longint      OUT_MAX   = 32767;
  localparam longint      OUT_MIN   = -32768;
  localparam int          RANDOM_BEATS = 1100;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  power_invariant_park_transform dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  // k*sin over a quarter turn, Q1.15, entries 0..N inclusive
  longint    ksin_rom [0:TAB_N];
  in_beat_t  stim_q[$];
  out_beat_t park_results_q[$];
  out_beat_t want_beat;
  logic      in_fire = 1'b0;
  int        beats_total = 0;
  int        beats_sent = 0;
  int        send_idle_pct = 37;
  int        recv_idle_pct = 47;
  int        errors = 0;
  int        fwd_checked = 0;
  int        inv_checked = 0;
  int        clipped_seen = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, park_results_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return longint'(root);
  endfunction

  // Taylor series to x^15 in Q2.30, scaled by sqrt(2/3), rounded to Q1.15
  function automatic longint scaled_sine(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned k_q30;
    x     = (longint'(HALF_PI_Q30) * idx) >> TAB_BITS;
    x2    = (x * x) >> 30;
    term  = x;
    acc   = x;
    k_q30 = floor_sqrt((64'd1 << 61) / 64'd3);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    acc = (acc * k_q30) >> 30;
    return longint'((acc + 64'd16384) >> 15);
  endfunction

  function automatic longint ksin_at(input logic [PHASE_W-1:0] ph);
    logic [TAB_BITS-1:0] j;
    longint v;
    j = ph[TAB_BITS-1:0];
    v = ph[TAB_BITS] ? ksin_rom[TAB_N - j] : ksin_rom[j];
    return ph[TAB_BITS+1] ? -v : v;
  endfunction

  function automatic out_beat_t park_predict(input in_beat_t b);
    logic [PHASE_W-1:0] ph;
    longint sn, cs, a, q, c, al, be, u, v, uh;
    longint res [3];
    out_beat_t r;
    // low angle bits are simply dropped
    ph = b.theta[ANGLE_BITS-1 -: PHASE_W];
    sn = ksin_at(ph);
    cs = ksin_at(ph + PHASE_W'(TAB_N));
    a  = $signed(b.in_a);
    q  = $signed(b.in_b);
    c  = $signed(b.in_c);
    if (b.cmd == CMD_FWD) begin
      al = 2 * a - q - c;
      be = (SQRT3_Q16 * (q - c) + 64'sd32768) >>> 16;
      res[0] = (cs * al + sn * be + 64'sd32768) >>> 16;
      res[1] = (cs * be - sn * al + 64'sd32768) >>> 16;
      res[2] = 0;
    end else begin
      u  = cs * a - sn * q;
      v  = sn * a + cs * q;
      uh = -u * 65536;
      res[0] = (u + 64'sd16384) >>> 15;
      res[1] = (uh + SQRT3_Q16 * v + 64'sd2147483648) >>> 32;
      res[2] = (uh - SQRT3_Q16 * v + 64'sd2147483648) >>> 32;
    end
    r.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (res[i] > OUT_MAX) begin
        res[i] = OUT_MAX;
        r.saturated = 1'b1;
      end else if (res[i] < OUT_MIN) begin
        res[i] = OUT_MIN;
        r.saturated = 1'b1;
      end
    end
    r.out_a = res[0][SAMPLE_BITS-1:0];
    r.out_b = res[1][SAMPLE_BITS-1:0];
    r.out_c = res[2][SAMPLE_BITS-1:0];
    return r;
  endfunction

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_beat(input out_beat_t want, input out_beat_t got);
    report_field("out_a", $signed(want.out_a), $signed(got.out_a));
    report_field("out_b", $signed(want.out_b), $signed(got.out_b));
    report_field("out_c", $signed(want.out_c), $signed(got.out_c));
    report_field("saturated", want.saturated, got.saturated);
    if (want.saturated) clipped_seen++;
  endtask

  task automatic add_beat(input cmd_e cmd, input logic [ANGLE_BITS-1:0] theta,
                          input logic signed [SAMPLE_BITS-1:0] a,
                          input logic signed [SAMPLE_BITS-1:0] b,
                          input logic signed [SAMPLE_BITS-1:0] c);
    in_beat_t t;
    t.cmd   = cmd;
    t.theta = theta;
    t.in_a  = a;
    t.in_b  = b;
    t.in_c  = c;
    stim_q = {stim_q, t};
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_BITS'($signed($urandom_range(511)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Driver: new beat only when the line is free or the last beat was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (beats_sent < beats_total / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 47;
      end else if (beats_sent < 2 * beats_total / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!in_valid_i || in_fire) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_beat_i  <= stim_q.pop_front();
          in_valid_i <= 1'b1;
          beats_sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on every accepted input beat, check every result beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) park_results_q = {park_results_q, park_predict(in_beat_i)};
      if (out_valid_o && out_ready_i) begin
        if (park_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got a=%0d b=%0d c=%0d sat=%0b",
                   $time, out_beat_o.out_a, out_beat_o.out_b, out_beat_o.out_c,
                   out_beat_o.saturated);
          errors++;
        end else begin
          want_beat = park_results_q.pop_front();
          check_beat(want_beat, out_beat_o);
        end
      end
    end
  end

  // Count modes on the input side so the summary reflects what was exercised
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (in_beat_i.cmd == CMD_FWD) fwd_checked++;
      else inv_checked++;
    end
  end

  initial begin
    for (int i = 0; i <= TAB_N; i++) ksin_rom[i] = scaled_sine(i);

    // directed: angle extremes, quadrant edges, dropped angle bits, clipping
    add_beat(CMD_FWD, 16'h0000, 16'sh7FFF, 16'sh0000, 16'sh0000);
    add_beat(CMD_FWD, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    add_beat(CMD_FWD, 16'h0000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_beat(CMD_FWD, 16'h4000, 16'sh7FFF, 16'sh8000, 16'sh8000);
    add_beat(CMD_FWD, 16'h8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    add_beat(CMD_FWD, 16'hC000, 16'sh0000, 16'sh7FFF, 16'sh8000);
    add_beat(CMD_FWD, 16'h000F, 16'sd20000, -16'sd10000, -16'sd10000);
    add_beat(CMD_FWD, 16'h0010, 16'sd20000, -16'sd10000, -16'sd10000);
    add_beat(CMD_FWD, 16'h2AAA, 16'sd16000, -16'sd8000, -16'sd8000);
    add_beat(CMD_FWD, 16'h3FFF, 16'sh7FFF, 16'sh8000, 16'sh0000);
    add_beat(CMD_INV, 16'h0000, 16'sh7FFF, 16'sh0000, 16'sd12345);
    add_beat(CMD_INV, 16'h4000, 16'sh8000, 16'sh7FFF, -16'sd1);
    add_beat(CMD_INV, 16'h8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    add_beat(CMD_INV, 16'hC000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_beat(CMD_INV, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    add_beat(CMD_INV, 16'h000F, 16'sh0000, 16'sh0000, 16'sh8000);
    // full-scale d/q swept around the turn drives the phase outputs past range
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) add_beat(CMD_INV, 16'(k * 16'h2000 + 16'h1555), 16'sh7FFF, 16'sh7FFF,
                               16'sh0000);
      else add_beat(CMD_INV, 16'(k * 16'h2000 + 16'h1555), 16'sh8000, 16'sh8000, 16'sh7FFF);
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      add_beat(($urandom_range(1) != 0) ? CMD_INV : CMD_FWD, ANGLE_BITS'($urandom),
               rand_sample(), rand_sample(), rand_sample());
    end
    beats_total = stim_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (park_results_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Transformed %0d beats (%0d abc->dq, %0d dq->abc); %0d results clipped.",
             fwd_checked + inv_checked, fwd_checked, inv_checked, clipped_seen);
    $display("Mismatches: %0d, results still owed: %0d", errors, park_results_q.size());
    if (errors == 0 && park_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
